// ----- hw/rtl/pgn_pkg.sv -----
// Package for the gradient noise unit: types, constants and arithmetic helpers.
`timescale 1ns / 1ps
package pgn_pkg;

  localparam int unsigned TableSizeDef     = 256;
  localparam int unsigned CoordFracBitsDef = 16;
  localparam int unsigned OutFracBitsDef   = 14;
  localparam int unsigned CoordW           = 32;
  localparam int unsigned WorkFrac         = 16;
  localparam int unsigned OffW             = 18;  // f or f - ONE
  localparam int unsigned GradW            = 19;  // +/-u +/-v
  localparam int unsigned FadeW            = 17;
  localparam int unsigned NoiseW           = 16;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_3D   = 2'd1,
    REQ_2D   = 2'd2,
    REQ_NONE = 2'd3
  } req_type_e;

  typedef logic [3:0] hnib_t;

  typedef struct packed {
    logic en;   // pipeline advance
    logic ld1;  // load item in stage 1
    logic ld2;
    logic ld3;
  } hash_ctl_t;

  typedef struct packed {
    hnib_t [7:0] h3;  // aa, ba, ab, bb, then the same +1 for the far z plane
    hnib_t [3:0] h2;  // aa, ba, ab, bb of the two-level hash
  } hash_out_t;

  function automatic logic signed [GradW-1:0] grad(
    input hnib_t                  h,
    input logic signed [OffW-1:0] dx,
    input logic signed [OffW-1:0] dy,
    input logic signed [OffW-1:0] dz
  );
    logic signed [GradW-1:0] u;
    logic signed [GradW-1:0] v;
    u = (h < 4'd8) ? GradW'(dx) : GradW'(dy);
    if (h < 4'd4) begin
      v = GradW'(dy);
    end else if (h == 4'd12 || h == 4'd14) begin
      v = GradW'(dx);
    end else begin
      v = GradW'(dz);
    end
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return u + v;
  endfunction

  // a + floor((b - a) * w / 2^16)
  function automatic logic signed [GradW-1:0] blend(
    input logic signed [GradW-1:0] a,
    input logic signed [GradW-1:0] b,
    input logic        [FadeW-1:0] w
  );
    logic signed [GradW:0]         diff;
    logic signed [GradW+FadeW+1:0] prod;
    logic signed [GradW+FadeW+1:0] shr;
    logic signed [GradW:0]         sum;
    diff = (GradW+1)'(b) - (GradW+1)'(a);
    prod = diff * $signed({1'b0, w});
    shr  = prod >>> WorkFrac;
    sum  = (GradW+1)'(a) + shr[GradW:0];
    return sum[GradW-1:0];
  endfunction

endpackage

// ----- hw/rtl/pgn_ram.sv -----
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module pgn_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr0_i,
  input  logic [$clog2(Depth)-1:0] raddr1_i,
  output logic [Width-1:0]         rdata0_o,
  output logic [Width-1:0]         rdata1_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

// ----- hw/rtl/pgn_fade.sv -----
// Three-stage quintic fade curve 6t^5 - 15t^4 + 10t^3 on a Q0.16 input.
`timescale 1ns / 1ps
module pgn_fade (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [15:0]                t_i,
  output logic [pgn_pkg::FadeW-1:0]  fade_o
);
  import pgn_pkg::*;

  logic [15:0] ta_q;
  logic [31:0] tt_q;
  logic [15:0] t3_q;
  logic [19:0] poly_q;
  logic [31:0] t3_d;
  logic [36:0] poly_d;
  logic [35:0] fp_d;

  always_comb begin
    t3_d   = tt_q[31:16] * ta_q;
    poly_d = 37'(tt_q) * 37'd6 + (37'd10 << 32) - ((37'(ta_q) * 37'd15) << 16);
    fp_d   = t3_q * poly_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ta_q   <= t_i;
      tt_q   <= t_i * t_i;
      t3_q   <= t3_d[31:16];
      poly_q <= poly_d[35:16];
      fade_o <= fp_d[FadeW+15:16];
    end
  end

endmodule

// ----- hw/rtl/pgn_hash.sv -----
// Three levels of permutation lookups, each level on its own table copies.
`timescale 1ns / 1ps
module pgn_hash #(
  parameter int unsigned TableSize = pgn_pkg::TableSizeDef
) (
  input  logic                         clk_i,
  input  pgn_pkg::hash_ctl_t           ctl_i,
  input  logic [$clog2(TableSize)-1:0] cx_i,
  input  logic [$clog2(TableSize)-1:0] cy_i,
  input  logic [$clog2(TableSize)-1:0] cz_i,
  input  logic [$clog2(TableSize)-1:0] widx_i,
  input  logic [7:0]                   wval_i,
  output pgn_pkg::hash_out_t           hash_o
);
  import pgn_pkg::*;

  localparam int unsigned IdxW = $clog2(TableSize);
  localparam logic [IdxW-1:0] One = IdxW'(1);

  logic [IdxW-1:0] cy2_q, cz2_q, cz3_q, widx2_q, widx3_q;
  logic [7:0]      wval2_q, wval3_q;
  logic [7:0]      p0, p1, qa0, qa1, qb0, qb1;
  logic [7:0]      r3 [8];
  logic [IdxW-1:0] a2, b2;
  logic [IdxW-1:0] l3 [4];
  hnib_t [3:0]     h2_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      cy2_q   <= cy_i;
      cz2_q   <= cz_i;
      cz3_q   <= cz2_q;
      widx2_q <= widx_i;
      widx3_q <= widx2_q;
      wval2_q <= wval_i;
      wval3_q <= wval2_q;
      h2_q    <= {qb1[3:0], qa1[3:0], qb0[3:0], qa0[3:0]};
    end
  end

  pgn_ram #(.Width(8), .Depth(TableSize)) u_l1 (
    .clk_i, .we_i(ctl_i.en && ctl_i.ld1), .waddr_i(widx_i), .wdata_i(wval_i),
    .re_i(ctl_i.en), .raddr0_i(cx_i), .raddr1_i(cx_i + One),
    .rdata0_o(p0), .rdata1_o(p1)
  );

  assign a2 = IdxW'(p0) + cy2_q;
  assign b2 = IdxW'(p1) + cy2_q;

  pgn_ram #(.Width(8), .Depth(TableSize)) u_l2a (
    .clk_i, .we_i(ctl_i.en && ctl_i.ld2), .waddr_i(widx2_q), .wdata_i(wval2_q),
    .re_i(ctl_i.en), .raddr0_i(a2), .raddr1_i(a2 + One),
    .rdata0_o(qa0), .rdata1_o(qa1)
  );

  pgn_ram #(.Width(8), .Depth(TableSize)) u_l2b (
    .clk_i, .we_i(ctl_i.en && ctl_i.ld2), .waddr_i(widx2_q), .wdata_i(wval2_q),
    .re_i(ctl_i.en), .raddr0_i(b2), .raddr1_i(b2 + One),
    .rdata0_o(qb0), .rdata1_o(qb1)
  );

  // lane order aa, ba, ab, bb
  assign l3[0] = IdxW'(qa0) + cz3_q;
  assign l3[1] = IdxW'(qb0) + cz3_q;
  assign l3[2] = IdxW'(qa1) + cz3_q;
  assign l3[3] = IdxW'(qb1) + cz3_q;

  for (genvar g = 0; g < 4; g++) begin : g_l3
    pgn_ram #(.Width(8), .Depth(TableSize)) u_l3 (
      .clk_i, .we_i(ctl_i.en && ctl_i.ld3), .waddr_i(widx3_q), .wdata_i(wval3_q),
      .re_i(ctl_i.en), .raddr0_i(l3[g]), .raddr1_i(l3[g] + One),
      .rdata0_o(r3[g]), .rdata1_o(r3[g+4])
    );
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hash_o.h3[i] = r3[i][3:0];
    end
    hash_o.h2 = h2_q;
  end

endmodule

// ----- hw/rtl/perlin_gradient_noise_unit.sv -----
// Top level of the gradient noise unit: request pipeline, gradients and blends.
//
//  channel | valid         | stall         | payload
//  --------+---------------+---------------+--------------------------------------
//  request | req_valid_i   | req_stall_o   | req_type_i, coord_*_i, perm_*_i
//  result  | noise_valid_o | noise_stall_i | noise_value_o
//
// One request per cycle while no result is stalled; each evaluation runs through
// three table lookup levels with registered reads, then gradient, x, y and z blend
// stages, each blend one multiplier deep.
// Loads pass down the pipe and write each table copy at the stage that reads it.
// Reset clears the valid, load and 2D flags only; the table holds garbage until loaded.
// A stalled result freezes the whole pipe; req_stall_o is high exactly then.
`timescale 1ns / 1ps
module perlin_gradient_noise_unit #(
  parameter int unsigned TABLE_SIZE      = pgn_pkg::TableSizeDef,
  parameter int unsigned COORD_FRAC_BITS = pgn_pkg::CoordFracBitsDef,
  parameter int unsigned OUT_FRAC_BITS   = pgn_pkg::OutFracBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                req_valid_i,
  output logic                                req_stall_o,
  input  logic [1:0]                          req_type_i,
  input  logic signed [pgn_pkg::CoordW-1:0]   coord_x_i,
  input  logic signed [pgn_pkg::CoordW-1:0]   coord_y_i,
  input  logic signed [pgn_pkg::CoordW-1:0]   coord_z_i,
  input  logic [7:0]                          perm_index_i,
  input  logic [7:0]                          perm_value_i,
  output logic                                noise_valid_o,
  input  logic                                noise_stall_i,
  output logic signed [pgn_pkg::NoiseW-1:0]   noise_value_o
);
  import pgn_pkg::*;

  localparam int unsigned IdxW  = $clog2(TABLE_SIZE);
  localparam int unsigned ExtW  = CoordW + IdxW;
  localparam int unsigned UpSh  = (OUT_FRAC_BITS > WorkFrac) ? OUT_FRAC_BITS - WorkFrac : 0;
  localparam int unsigned DnSh  = (OUT_FRAC_BITS < WorkFrac) ? WorkFrac - OUT_FRAC_BITS : 0;
  localparam int unsigned ScW   = GradW + UpSh;
  localparam logic signed [OffW-1:0] OneQ = OffW'(1 << WorkFrac);

  logic adv;
  logic [7:0] ev_q;   // evaluation in stage 1..8 (bit 7 is the output register)
  logic [2:0] ld_q;   // load in stage 1..3
  logic [3:0] is2d_q;
  logic ev_in, ld_in;

  logic [15:0]     f_in [3];
  logic [15:0]     f_q  [4][3];
  logic [IdxW-1:0] c_q  [3];
  logic [IdxW-1:0] widx_q;
  logic [7:0]      wval_q;
  logic signed [ExtW-1:0] ext [3];

  logic [FadeW-1:0] fade [3];
  hash_ctl_t        hctl;
  hash_out_t        hout;

  logic signed [GradW-1:0] g_d [8];
  logic signed [GradW-1:0] g5_q [8];
  logic [FadeW-1:0]        u5_q, v5_q, w5_q, v6_q, w6_q, w7_q;
  logic signed [GradW-1:0] xl6_q [4];
  logic signed [GradW-1:0] yl7_q [2];
  logic signed [GradW-1:0] r_d;
  logic signed [ScW-1:0]   sc_d;
  logic signed [NoiseW-1:0] out_d;

  assign adv         = !(ev_q[7] && noise_stall_i);
  assign req_stall_o = !adv;
  assign ev_in = req_valid_i && (req_type_i == REQ_3D || req_type_i == REQ_2D);
  assign ld_in = req_valid_i && (req_type_i == REQ_LOAD);

  assign ext[0] = ExtW'(coord_x_i);
  assign ext[1] = ExtW'(coord_y_i);
  assign ext[2] = ExtW'(coord_z_i);

  for (genvar k = 0; k < 3; k++) begin : g_frac
    if (COORD_FRAC_BITS >= WorkFrac) begin : g_trunc
      assign f_in[k] = ext[k][COORD_FRAC_BITS-1 -: WorkFrac];
    end else begin : g_pad
      assign f_in[k] = {ext[k][COORD_FRAC_BITS-1:0], (WorkFrac - COORD_FRAC_BITS)'(0)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q   <= '0;
      ld_q   <= '0;
      is2d_q <= '0;
    end else if (adv) begin
      ev_q   <= {ev_q[6:0], ev_in};
      ld_q   <= {ld_q[1:0], ld_in};
      is2d_q <= {is2d_q[2:0], req_type_i == REQ_2D};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        c_q[k]    <= ext[k][COORD_FRAC_BITS +: IdxW];
        // z plays no part in 2D
        f_q[0][k] <= (k == 2 && req_type_i == REQ_2D) ? '0 : f_in[k];
      end
      for (int s = 1; s < 4; s++) begin
        f_q[s] <= f_q[s-1];
      end
      widx_q <= IdxW'(perm_index_i);
      wval_q <= perm_value_i;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_fade
    pgn_fade u_fade (.clk_i, .en_i(adv), .t_i(f_q[0][k]), .fade_o(fade[k]));
  end

  assign hctl = '{en: adv, ld1: ld_q[0], ld2: ld_q[1], ld3: ld_q[2]};

  pgn_hash #(.TableSize(TABLE_SIZE)) u_hash (
    .clk_i, .ctl_i(hctl), .cx_i(c_q[0]), .cy_i(c_q[1]), .cz_i(c_q[2]),
    .widx_i(widx_q), .wval_i(wval_q), .hash_o(hout)
  );

  // stage 4: gradients at the eight corners
  always_comb begin
    logic signed [OffW-1:0] x0, y0, z0, x1, y1, z1;
    x0 = OffW'(f_q[3][0]);
    y0 = OffW'(f_q[3][1]);
    z0 = OffW'(f_q[3][2]);
    x1 = x0 - OneQ;
    y1 = y0 - OneQ;
    z1 = z0 - OneQ;
    if (is2d_q[3]) begin
      g_d[0] = grad(hout.h2[0], x0, y0, '0);
      g_d[1] = grad(hout.h2[1], x1, y0, '0);
      g_d[2] = grad(hout.h2[2], x0, y1, '0);
      g_d[3] = grad(hout.h2[3], x1, y1, '0);
    end else begin
      g_d[0] = grad(hout.h3[0], x0, y0, z0);
      g_d[1] = grad(hout.h3[1], x1, y0, z0);
      g_d[2] = grad(hout.h3[2], x0, y1, z0);
      g_d[3] = grad(hout.h3[3], x1, y1, z0);
    end
    g_d[4] = grad(hout.h3[4], x0, y0, z1);
    g_d[5] = grad(hout.h3[5], x1, y0, z1);
    g_d[6] = grad(hout.h3[6], x0, y1, z1);
    g_d[7] = grad(hout.h3[7], x1, y1, z1);
  end

  // z fade is zero in 2D, so the z blend passes the near plane through
  always_comb begin
    r_d  = blend(yl7_q[0], yl7_q[1], w7_q);
    sc_d = (ScW'(r_d) <<< UpSh) >>> DnSh;
    if (sc_d > ScW'(32767)) begin
      out_d = 16'sh7fff;
    end else if (sc_d < -ScW'(32768)) begin
      out_d = -16'sh8000;
    end else begin
      out_d = sc_d[NoiseW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g5_q <= g_d;
      u5_q <= fade[0];
      v5_q <= fade[1];
      w5_q <= fade[2];
      for (int i = 0; i < 4; i++) begin
        xl6_q[i] <= blend(g5_q[2*i], g5_q[2*i+1], u5_q);
      end
      v6_q <= v5_q;
      w6_q <= w5_q;
      yl7_q[0] <= blend(xl6_q[0], xl6_q[1], v6_q);
      yl7_q[1] <= blend(xl6_q[2], xl6_q[3], v6_q);
      w7_q <= w6_q;
      noise_value_o <= out_d;
    end
  end

  assign noise_valid_o = ev_q[7];

endmodule

// ----- hw/rtl/pgn_checker.sv -----
// Port-level checks of the gradient noise unit, bound to the top level.
`timescale 1ns / 1ps
module pgn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_stall_o,
  input logic        noise_valid_o,
  input logic        noise_stall_i,
  input logic [15:0] noise_value_o
);

  // request stall comes only from a result held downstream
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_stall_o |-> (noise_valid_o && noise_stall_i))
    else $error("request stall without a stalled result");

  // a new result appears only after the pipe advanced
  a_rise_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(noise_valid_o) |-> $past(!req_stall_o))
    else $error("result appeared while pipe was frozen");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (noise_valid_o && noise_stall_i) |=> noise_valid_o)
    else $error("stalled result dropped");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (noise_valid_o && noise_stall_i) |=> $stable(noise_value_o))
    else $error("stalled result changed");

endmodule

bind perlin_gradient_noise_unit pgn_checker u_pgn_checker (.*);
